[hdl/udkl_pkg.sv]
package udkl_pkg;

    localparam int unsigned InWidth    = 8;
    localparam int unsigned OutWidth   = 16;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 16;
    localparam int unsigned LevelW     = 6;

    localparam logic [LevelW-1:0] LevelMax  = 6'd63;
    localparam logic [7:0]        StableMax = 8'd255;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] RegDebounce = 3'd0;
    localparam logic [CfgIdxW-1:0] RegHeldSat  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegStuck    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegShort    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegRepeat   = 3'd4;

    localparam logic [7:0]  DebounceReset = 8'd3;
    localparam logic [15:0] HeldSatReset  = 16'd3000;
    localparam logic [15:0] StuckReset    = 16'd3000;
    localparam logic [7:0]  ShortReset    = 8'd50;
    localparam logic [7:0]  RepeatReset   = 8'd20;

    // error codes
    localparam logic [1:0] ErrNone  = 2'd0;
    localparam logic [1:0] ErrPlus  = 2'd1;
    localparam logic [1:0] ErrMinus = 2'd2;
    localparam logic [1:0] ErrBoth  = 2'd3;

    localparam int unsigned KeyPlus  = 0;
    localparam int unsigned KeyMinus = 1;

    typedef struct packed {
        logic [7:0]  stable_time;
        logic        last_raw;
        logic        debounced;
        logic [15:0] held_time;
    } t_key;

    typedef struct packed {
        logic [7:0] press_time;
        logic       short_flag;
        logic       long_flag;
    } t_press;

    function automatic logic [LevelW-1:0] level_up(input logic [LevelW-1:0] lvl);
        level_up = (lvl == LevelMax) ? '0 : lvl + 1'b1;
    endfunction

    function automatic logic [LevelW-1:0] level_down(input logic [LevelW-1:0] lvl);
        level_down = (lvl == '0) ? LevelMax : lvl - 1'b1;
    endfunction

endpackage

[hdl/udkl_key_filter.sv]
module udkl_key_filter (
    input  logic               i_raw,
    input  udkl_pkg::t_key     i_state,
    input  logic [7:0]         i_debounce_ticks,
    input  logic [15:0]        i_held_sat,
    output udkl_pkg::t_key     o_state
);

    logic        act;
    logic [16:0] held_inc;

    always_comb begin
        act      = ~i_raw;
        o_state  = i_state;
        held_inc = '0;
        // release clears at once
        if (!act) begin
            o_state.debounced = 1'b0;
            o_state.last_raw  = 1'b0;
            o_state.held_time = '0;
        end
        if (o_state.stable_time != udkl_pkg::StableMax) begin
            o_state.stable_time = o_state.stable_time + 1'b1;
        end
        if (o_state.last_raw != act) begin
            o_state.stable_time = '0;
        end
        o_state.last_raw = act;
        if (o_state.stable_time >= i_debounce_ticks) begin
            held_inc          = {1'b0, o_state.held_time} + 17'd1;
            o_state.debounced = o_state.last_raw;
            // saturate and force release
            if (held_inc >= {1'b0, i_held_sat}) begin
                held_inc          = {1'b0, i_held_sat};
                o_state.debounced = 1'b0;
                o_state.last_raw  = 1'b0;
            end
            o_state.held_time = held_inc[15:0];
        end
    end

endmodule

[hdl/udkl_press_ctrl.sv]
module udkl_press_ctrl (
    input  udkl_pkg::t_key                         i_key_plus,
    input  udkl_pkg::t_key                         i_key_minus,
    input  logic                                   i_enable,
    input  logic                                   i_power_off,
    input  logic [15:0]                            i_stuck_limit,
    input  logic [7:0]                             i_short_ticks,
    input  logic [7:0]                             i_repeat_ticks,
    input  udkl_pkg::t_press [1:0]                 i_press,
    input  logic [7:0]                             i_repeat,
    input  logic [udkl_pkg::LevelW-1:0]            i_level,
    input  logic                                   i_sync,
    output udkl_pkg::t_press [1:0]                 o_press,
    output logic [7:0]                             o_repeat,
    output logic [udkl_pkg::LevelW-1:0]            o_level,
    output logic                                   o_sync,
    output logic [1:0]                             o_error
);

    logic       plus_stuck;
    logic       minus_stuck;
    logic       sel;
    logic [8:0] press_inc;

    always_comb begin
        o_press     = i_press;
        o_repeat    = i_repeat;
        o_level     = i_level;
        o_sync      = i_sync;
        o_error     = udkl_pkg::ErrNone;
        sel         = 1'b0;
        press_inc   = '0;
        plus_stuck  = i_key_plus.held_time >= i_stuck_limit;
        minus_stuck = i_key_minus.held_time >= i_stuck_limit;

        if (plus_stuck && minus_stuck) begin
            o_press = '0;
            o_error = udkl_pkg::ErrBoth;
        end else if (plus_stuck) begin
            o_press[udkl_pkg::KeyPlus] = '0;
            o_error = udkl_pkg::ErrPlus;
        end else if (minus_stuck) begin
            o_press[udkl_pkg::KeyMinus] = '0;
            o_error = udkl_pkg::ErrMinus;
        end else begin
            if (i_key_plus.debounced && i_key_minus.debounced) begin
                o_press  = '0;
                o_repeat = '0;
            end else if (i_enable && (i_key_plus.debounced || i_key_minus.debounced)) begin
                // select the pressed key; both keys pressed is handled above
                sel       = !i_key_plus.debounced;
                press_inc = {1'b0, o_press[sel].press_time} + 9'd1;
                if (press_inc >= {1'b0, i_short_ticks}) begin
                    o_press[sel].press_time = i_short_ticks;
                    o_press[sel].long_flag  = 1'b1;
                    o_press[sel].short_flag = 1'b0;
                    o_repeat                = o_repeat + 1'b1;
                end else begin
                    o_press[sel].press_time = press_inc[7:0];
                    o_press[sel].short_flag = 1'b1;
                    o_press[sel].long_flag  = 1'b0;
                end
            end else begin
                o_press[udkl_pkg::KeyPlus].press_time  = '0;
                o_press[udkl_pkg::KeyMinus].press_time = '0;
                o_press[udkl_pkg::KeyPlus].long_flag   = 1'b0;
                o_press[udkl_pkg::KeyMinus].long_flag  = 1'b0;
                o_repeat = '0;
                // short press steps on release
                if (o_press[udkl_pkg::KeyPlus].short_flag) begin
                    o_press[udkl_pkg::KeyPlus].short_flag = 1'b0;
                    o_sync  = 1'b1;
                    o_level = udkl_pkg::level_up(o_level);
                end
                if (o_press[udkl_pkg::KeyMinus].short_flag) begin
                    o_press[udkl_pkg::KeyMinus].short_flag = 1'b0;
                    o_sync  = 1'b1;
                    o_level = udkl_pkg::level_down(o_level);
                end
            end
            if (o_repeat >= i_repeat_ticks && o_press[udkl_pkg::KeyPlus].long_flag) begin
                o_repeat = '0;
                o_sync   = 1'b1;
                o_level  = udkl_pkg::level_up(o_level);
            end
            if (o_repeat >= i_repeat_ticks && o_press[udkl_pkg::KeyMinus].long_flag) begin
                o_repeat = '0;
                o_sync   = 1'b1;
                o_level  = udkl_pkg::level_down(o_level);
            end
        end

        if (i_power_off) begin
            o_sync  = 1'b0;
            o_level = '0;
        end
    end

endmodule

[hdl/udkl_out_skid.sv]
module udkl_out_skid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [udkl_pkg::OutWidth-1:0]     i_data,
    output logic                              o_ready,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [udkl_pkg::OutWidth-1:0]     m_axis_tdata
);

    logic                          r_out_valid;
    logic [udkl_pkg::OutWidth-1:0] r_out_data;
    logic                          r_skid_valid;
    logic [udkl_pkg::OutWidth-1:0] r_skid_data;
    logic                          load_out;

    assign load_out      = !r_out_valid || m_axis_tready;
    assign o_ready       = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            if (r_skid_valid) begin
                // drain skid first; no new transfer while it is full
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_valid) begin
                r_out_data <= i_data;
            end
        end else if (i_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

[hdl/updown_key_level_with_autorepeat.sv]
// Up/down key level stepper with debounce, stuck detection and auto-repeat.
// Input stream: one transfer per timer tick. s_axis_tdata carries the raw
// active-low plus and minus key levels and the enable and power-off flags.
// Output stream: one result transfer per input transfer, in order, holding the
// stepped 6-bit level, stuck-key error code, sync flag and debounced key states.
// Configuration: write channel (i_cfg_valid/o_cfg_ready, register index and
// data); o_cfg_ready is always high. Write only while the block is idle.
// Output: each result is registered in the output buffer before it shows on m_axis.
// Throughput: one item per cycle while s_axis_tready is high; all key and level
// state updates in one combinational pass from input handshake to output reg.
// Stall: a two-entry output register/skid pair keeps s_axis_tready high while
// one result waits; s_axis_tready drops only when both entries are full.
// Reset (synchronous, active low): all key, press and level state clears,
// configuration returns to its defaults and the output buffer empties.
module updown_key_level_with_autorepeat (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: [0] raw_plus, [1] raw_minus, [2] enable, [3] power_off, [7:4] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [udkl_pkg::InWidth-1:0]      s_axis_tdata,
    // tdata: [5:0] level, [7:6] error_code, [8] sync_flag, [9] plus_pressed,
    //        [10] minus_pressed, [15:11] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [udkl_pkg::OutWidth-1:0]     m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [udkl_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [udkl_pkg::CfgDataW-1:0]     i_cfg_data
);

    logic [7:0]  r_debounce_ticks;
    logic [15:0] r_held_sat;
    logic [15:0] r_stuck_limit;
    logic [7:0]  r_short_ticks;
    logic [7:0]  r_repeat_ticks;

    udkl_pkg::t_key                  r_key_plus;
    udkl_pkg::t_key                  r_key_minus;
    udkl_pkg::t_press [1:0]          r_press;
    logic [7:0]                      r_repeat;
    logic [udkl_pkg::LevelW-1:0]     r_level;
    logic                            r_sync;

    udkl_pkg::t_key                  n_key_plus;
    udkl_pkg::t_key                  n_key_minus;
    udkl_pkg::t_press [1:0]          n_press;
    logic [7:0]                      n_repeat;
    logic [udkl_pkg::LevelW-1:0]     n_level;
    logic                            n_sync;
    logic [1:0]                      error_code;

    logic                            in_xfer;
    logic [udkl_pkg::OutWidth-1:0]   result;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= udkl_pkg::DebounceReset;
            r_held_sat       <= udkl_pkg::HeldSatReset;
            r_stuck_limit    <= udkl_pkg::StuckReset;
            r_short_ticks    <= udkl_pkg::ShortReset;
            r_repeat_ticks   <= udkl_pkg::RepeatReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                udkl_pkg::RegDebounce: r_debounce_ticks <= i_cfg_data[7:0];
                udkl_pkg::RegHeldSat:  r_held_sat       <= i_cfg_data;
                udkl_pkg::RegStuck:    r_stuck_limit    <= i_cfg_data;
                udkl_pkg::RegShort:    r_short_ticks    <= i_cfg_data[7:0];
                udkl_pkg::RegRepeat:   r_repeat_ticks   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    udkl_key_filter u_filter_plus (
        .i_raw            (s_axis_tdata[0]),
        .i_state          (r_key_plus),
        .i_debounce_ticks (r_debounce_ticks),
        .i_held_sat       (r_held_sat),
        .o_state          (n_key_plus)
    );

    udkl_key_filter u_filter_minus (
        .i_raw            (s_axis_tdata[1]),
        .i_state          (r_key_minus),
        .i_debounce_ticks (r_debounce_ticks),
        .i_held_sat       (r_held_sat),
        .o_state          (n_key_minus)
    );

    udkl_press_ctrl u_press_ctrl (
        .i_key_plus     (n_key_plus),
        .i_key_minus    (n_key_minus),
        .i_enable       (s_axis_tdata[2]),
        .i_power_off    (s_axis_tdata[3]),
        .i_stuck_limit  (r_stuck_limit),
        .i_short_ticks  (r_short_ticks),
        .i_repeat_ticks (r_repeat_ticks),
        .i_press        (r_press),
        .i_repeat       (r_repeat),
        .i_level        (r_level),
        .i_sync         (r_sync),
        .o_press        (n_press),
        .o_repeat       (n_repeat),
        .o_level        (n_level),
        .o_sync         (n_sync),
        .o_error        (error_code)
    );

    // advance state on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_plus  <= '0;
            r_key_minus <= '0;
            r_press     <= '0;
            r_repeat    <= '0;
            r_level     <= '0;
            r_sync      <= 1'b0;
        end else if (in_xfer) begin
            r_key_plus  <= n_key_plus;
            r_key_minus <= n_key_minus;
            r_press     <= n_press;
            r_repeat    <= n_repeat;
            r_level     <= n_level;
            r_sync      <= n_sync;
        end
    end

    assign result = {5'b0, n_key_minus.debounced, n_key_plus.debounced, n_sync,
                     error_code, n_level};

    udkl_out_skid u_out_skid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_xfer),
        .i_data        (result),
        .o_ready       (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
